### hw/rtl/qs_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Quicksort package
// Shared data types and widths for the quicksort block.
// ----------------------------------------------------------------------------
package qs_pkg;

  localparam int unsigned DataW = 32;

  typedef logic signed [DataW-1:0] data_t;

endpackage
`default_nettype wire

### hw/rtl/qs_ram.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Quicksort RAM
// Synchronous memory with one write port and one registered read port.
// ----------------------------------------------------------------------------
module qs_ram #(
  parameter int unsigned Width = 32,
  parameter int unsigned Depth = 64,
  parameter int unsigned AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [AddrW-1:0] waddr_i,
  input  wire logic [Width-1:0] wdata_i,
  input  wire logic [AddrW-1:0] raddr_i,
  output logic      [Width-1:0] rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    rdata_o <= mem_q[raddr_i];
  end

endmodule
`default_nettype wire

### hw/rtl/quicksort_middle_pivot.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Quicksort with middle-element pivot
// Collects signed values and returns them in ascending order.
//
// An item is taken at a rising edge with start_i high and busy_o low. Each
// item carries one value; an item with last_item_i high closes the set and
// starts the sort. Up to MAX_ITEMS values are stored, and further items of the
// set are dropped and reported on overflow_o of every result of the run.
// Loading accepts one item per cycle. The sort runs on the value memory, whose
// single read port sets the pace: a partition reads the pivot, scans from the
// left and from the right, swaps each out-of-place pair and writes the pivot
// into place; the stack checks follow, then a step that loads the next range.
// The results then leave one per cycle, out_valid_o marking each for exactly
// one cycle and last_out_o the final one; the receiver cannot hold them off.
// The first result follows the final stack check by way of the S_OUT_RD read,
// and busy_o falls after the last one.
// Reset clears the controller, the fill count and the overflow flag; the
// memories need no clearing pass.
// ----------------------------------------------------------------------------
module quicksort_middle_pivot #(
  parameter int unsigned MAX_ITEMS = 64
) (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          start_i,
  output logic               busy_o,
  input  wire qs_pkg::data_t data_value_i,
  input  wire logic          last_item_i,
  output logic               out_valid_o,
  output qs_pkg::data_t      sorted_value_o,
  output logic               last_out_o,
  output logic               overflow_o
);

  import qs_pkg::*;

  localparam int unsigned IW  = $clog2(MAX_ITEMS);
  localparam int unsigned CW  = $clog2(MAX_ITEMS + 1);
  localparam int unsigned SD  = MAX_ITEMS / 2;
  localparam int unsigned SAW = (SD > 1) ? $clog2(SD) : 1;
  localparam int unsigned DW  = $clog2(SD + 1);
  localparam int unsigned EW  = 2 * IW;

  localparam logic [3:0] S_IDLE   = 4'd0;
  localparam logic [3:0] S_PIV_RD = 4'd1;
  localparam logic [3:0] S_PIV    = 4'd2;
  localparam logic [3:0] S_SCANL  = 4'd3;
  localparam logic [3:0] S_SCANR  = 4'd4;
  localparam logic [3:0] S_SWAP   = 4'd5;
  localparam logic [3:0] S_FIN    = 4'd6;
  localparam logic [3:0] S_PUSH1  = 4'd7;
  localparam logic [3:0] S_PUSH2  = 4'd8;
  localparam logic [3:0] S_POP    = 4'd9;
  localparam logic [3:0] S_POPW   = 4'd10;
  localparam logic [3:0] S_OUT_RD = 4'd11;
  localparam logic [3:0] S_OUT    = 4'd12;

  logic [3:0]    state_q, state_d;
  logic [CW-1:0] count_q, count_d;
  logic          dropped_q, dropped_d;
  logic [DW-1:0] depth_q, depth_d;
  logic [IW-1:0] k_q, k_d;
  logic [IW-1:0] lo_q, lo_d, hi_q, hi_d;
  logic [IW-1:0] left_q, left_d, right_q, right_d, piv_q, piv_d;
  data_t         pv_q, pv_d, vl_q, vl_d;

  logic             val_we;
  logic [IW-1:0]    val_waddr, val_raddr;
  logic [DataW-1:0] val_wdata, val_rdata;
  logic             stk_we;
  logic [SAW-1:0]   stk_waddr, stk_raddr;
  logic [EW-1:0]    stk_wdata, stk_rdata;

  logic [CW-1:0] next_cnt, cnt_m1;
  logic [DW-1:0] depth_m1;
  logic [IW:0]   mid_sum;
  logic          full;
  data_t         rd_val;

  qs_ram #(
    .Width(DataW),
    .Depth(MAX_ITEMS),
    .AddrW(IW)
  ) u_value_ram (
    .clk_i  (clk_i),
    .we_i   (val_we),
    .waddr_i(val_waddr),
    .wdata_i(val_wdata),
    .raddr_i(val_raddr),
    .rdata_o(val_rdata)
  );

  qs_ram #(
    .Width(EW),
    .Depth(SD),
    .AddrW(SAW)
  ) u_stack_ram (
    .clk_i  (clk_i),
    .we_i   (stk_we),
    .waddr_i(stk_waddr),
    .wdata_i(stk_wdata),
    .raddr_i(stk_raddr),
    .rdata_o(stk_rdata)
  );

  assign full     = (count_q == CW'(MAX_ITEMS));
  assign next_cnt = full ? count_q : count_q + CW'(1);
  assign cnt_m1   = count_q - CW'(1);
  assign depth_m1 = depth_q - DW'(1);
  assign mid_sum  = {1'b0, lo_q} + {1'b0, hi_q};
  assign rd_val   = $signed(val_rdata);

  always_comb begin
    state_d   = state_q;
    count_d   = count_q;
    dropped_d = dropped_q;
    depth_d   = depth_q;
    k_d       = k_q;
    lo_d      = lo_q;
    hi_d      = hi_q;
    left_d    = left_q;
    right_d   = right_q;
    piv_d     = piv_q;
    pv_d      = pv_q;
    vl_d      = vl_q;
    val_we    = 1'b0;
    val_waddr = left_q;
    val_wdata = val_rdata;
    val_raddr = left_q;
    stk_we    = 1'b0;
    stk_waddr = depth_q[SAW-1:0];
    stk_wdata = {lo_q, hi_q};
    stk_raddr = depth_m1[SAW-1:0];
    unique case (state_q)
      S_IDLE: begin
        if (start_i) begin
          if (!full) begin
            val_we    = 1'b1;
            val_waddr = count_q[IW-1:0];
            val_wdata = data_value_i;
          end else begin
            dropped_d = 1'b1;
          end
          count_d = next_cnt;
          if (last_item_i) begin
            lo_d    = '0;
            hi_d    = IW'(next_cnt - CW'(1));
            left_d  = '0;
            right_d = IW'(next_cnt - CW'(1));
            depth_d = '0;
            if (next_cnt < CW'(2)) begin
              state_d = S_OUT_RD;
            end else begin
              state_d = S_PIV_RD;
            end
          end
        end
      end
      S_PIV_RD: begin
        piv_d     = mid_sum[IW:1];
        val_raddr = mid_sum[IW:1];
        state_d   = S_PIV;
      end
      S_PIV: begin
        pv_d      = rd_val;
        val_raddr = left_q;
        state_d   = S_SCANL;
      end
      S_SCANL: begin
        if (left_q < right_q && rd_val < pv_q) begin
          left_d    = left_q + IW'(1);
          val_raddr = left_q + IW'(1);
        end else begin
          vl_d      = rd_val;
          val_raddr = right_q;
          state_d   = S_SCANR;
        end
      end
      S_SCANR: begin
        if (left_q < right_q && rd_val >= pv_q) begin
          right_d   = right_q - IW'(1);
          val_raddr = right_q - IW'(1);
        end else if (left_q < right_q) begin
          val_we    = 1'b1;
          val_waddr = left_q;
          val_wdata = val_rdata;
          state_d   = S_SWAP;
        end else begin
          val_we    = 1'b1;
          val_waddr = piv_q;
          val_wdata = val_rdata;
          state_d   = S_FIN;
        end
      end
      S_SWAP: begin
        val_we    = 1'b1;
        val_waddr = right_q;
        val_wdata = vl_q;
        if (left_q == piv_q) begin
          piv_d = right_q;
        end
        val_raddr = left_q;
        state_d   = S_SCANL;
      end
      S_FIN: begin
        val_we    = 1'b1;
        val_waddr = right_q;
        val_wdata = pv_q;
        state_d   = S_PUSH1;
      end
      S_PUSH1: begin
        if (({1'b0, right_q} + (IW+1)'(1)) < {1'b0, hi_q}) begin
          stk_we    = 1'b1;
          stk_wdata = {right_q + IW'(1), hi_q};
          depth_d   = depth_q + DW'(1);
        end
        state_d = S_PUSH2;
      end
      S_PUSH2: begin
        if (({1'b0, lo_q} + (IW+1)'(1)) < {1'b0, right_q}) begin
          stk_we    = 1'b1;
          stk_wdata = {lo_q, right_q - IW'(1)};
          depth_d   = depth_q + DW'(1);
        end
        state_d = S_POP;
      end
      S_POP: begin
        if (depth_q == '0) begin
          state_d = S_OUT_RD;
        end else begin
          depth_d = depth_m1;
          state_d = S_POPW;
        end
      end
      S_POPW: begin
        lo_d    = stk_rdata[EW-1:IW];
        hi_d    = stk_rdata[IW-1:0];
        left_d  = stk_rdata[EW-1:IW];
        right_d = stk_rdata[IW-1:0];
        state_d = S_PIV_RD;
      end
      S_OUT_RD: begin
        val_raddr = '0;
        k_d       = '0;
        state_d   = S_OUT;
      end
      S_OUT: begin
        val_raddr = k_q + IW'(1);
        if (CW'(k_q) == cnt_m1) begin
          count_d   = '0;
          dropped_d = 1'b0;
          state_d   = S_IDLE;
        end else begin
          k_d = k_q + IW'(1);
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      count_q   <= '0;
      dropped_q <= 1'b0;
      depth_q   <= '0;
      k_q       <= '0;
    end else begin
      state_q   <= state_d;
      count_q   <= count_d;
      dropped_q <= dropped_d;
      depth_q   <= depth_d;
      k_q       <= k_d;
    end
  end

  always_ff @(posedge clk_i) begin
    lo_q    <= lo_d;
    hi_q    <= hi_d;
    left_q  <= left_d;
    right_q <= right_d;
    piv_q   <= piv_d;
    pv_q    <= pv_d;
    vl_q    <= vl_d;
  end

  assign busy_o         = (state_q != S_IDLE);
  assign out_valid_o    = (state_q == S_OUT);
  assign sorted_value_o = rd_val;
  assign last_out_o     = out_valid_o && (CW'(k_q) == cnt_m1);
  assign overflow_o     = out_valid_o && dropped_q;

  a_out_busy : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> busy_o)
    else $error("Result strobe outside the busy phase.");

  a_last_idle : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && last_out_o) |=> !busy_o && !out_valid_o)
    else $error("Block still busy after the final result.");

  a_stack_bound : assert property (@(posedge clk_i) disable iff (!rst_ni)
    depth_q <= DW'(SD))
    else $error("Range stack exceeds its depth.");

  a_scan_order : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_SWAP) |-> (left_q < right_q))
    else $error("Swap with crossed scan indexes.");

endmodule
`default_nettype wire
